FILE: rtl/task_table_round_robin_sched_core_defines.svh
// Assertion macros used by the port checker of the task table scheduler.
// Depends on nothing; each macro expects signals clk and rst_n in scope.
`ifndef TASK_TABLE_ROUND_ROBIN_SCHED_CORE_DEFINES_SVH
`define TASK_TABLE_ROUND_ROBIN_SCHED_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TTS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tts_pkg.sv
// Shared types and codes of the task table scheduler.
// Depends on nothing; used by every module of the block but tts_queue.
`default_nettype none
package tts_pkg;

    // Table size is tied to the 3-bit slot fields of the interface.
    localparam int MAX_TASKS = 8;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_DELAY  = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_SCHED  = 3'd4;
    localparam logic [2:0] OP_QUIT   = 3'd5;
    localparam logic [2:0] OP_START  = 3'd6;
    localparam logic [2:0] OP_STOP   = 3'd7;

    localparam logic [1:0] ST_READY    = 2'd0;
    localparam logic [1:0] ST_RUNNING  = 2'd1;
    localparam logic [1:0] ST_SLEEPING = 2'd2;
    localparam logic [1:0] ST_DEAD     = 2'd3;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_FULL = 2'd1;
    localparam logic [1:0] ERR_NONE = 2'd2;

    localparam logic [7:0] TICK_DEC_RESET = 8'd2;

    typedef struct packed {
        logic add;
        logic remove;
        logic delay;
        logic tick;
        logic sched;
        logic quit;
        logic start;
        logic stop;
    } op_flags_t;

    typedef struct packed {
        op_flags_t          flags;
        logic [7:0]         task_id;
        logic signed [31:0] sleep_ticks;
        logic [2:0]         slot_select;
    } cmd_t;

    typedef struct packed {
        logic        run_valid;
        logic [2:0]  run_slot;
        logic [7:0]  run_task_id;
        logic [1:0]  slot_status;
        logic [15:0] restarts;
        logic [3:0]  task_count;
        logic [1:0]  error_code;
    } res_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [1:0]  status;
        logic [15:0] restarts;
        logic [31:0] sleep_left;
        logic        sleeping;
    } entry_t;

endpackage
`default_nettype wire

FILE: rtl/task_table_round_robin_sched_core.sv
// Top level of the round-robin task scheduler with sleep timers.
// Depends on tts_pkg, tts_front, tts_queue and tts_back.
//
//  channel   handshake            accepted when
//  --------  -------------------  -----------------------------------
//  request   push / full          push && !full
//  result    empty / pop          pop && !empty
//  config    psel/penable/pwrite  psel && penable && pwrite (pready=1)
//
// Every request gives exactly one result. A request is held in the front
// register, written into the command queue and then executed against the
// task table, whose result register drives the ports. A new request can be
// taken every cycle while results are drained.
// Reset clears the table, counters and pointers at once; no clearing pass.
// A stalled result holds the execution stage, then fills the queue, then
// raises full.
`default_nettype none
module task_table_round_robin_sched_core #(
    parameter int CMD_QUEUE_DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         opcode,
    input  wire logic [7:0]         task_id,
    input  wire logic signed [31:0] sleep_ticks,
    input  wire logic [2:0]         slot_select,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    run_valid,
    output logic [2:0]              run_slot,
    output logic [7:0]              run_task_id,
    output logic [1:0]              slot_status,
    output logic [15:0]             restarts,
    output logic [3:0]              task_count,
    output logic [1:0]              error_code
);
    import tts_pkg::*;

    logic [7:0] tick_dec_reg;
    logic       cfg_wr;
    logic       f_valid, f_ready;
    cmd_t       f_cmd;
    logic       q_valid, q_pop;
    cmd_t       q_cmd;
    res_t       res;

    // Register 0 sits at byte address zero; other addresses read as zero.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? {24'd0, tick_dec_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_dec_reg <= TICK_DEC_RESET;
        else if (cfg_wr)
            tick_dec_reg <= pwdata[7:0];
    end

    // Decode the request and hold it for the queue.
    tts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .task_id     (task_id),
        .sleep_ticks (sleep_ticks),
        .slot_select (slot_select),
        .cmd_valid   (f_valid),
        .cmd         (f_cmd),
        .cmd_ready   (f_ready)
    );

    // Decouple decode from execution.
    tts_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid),
        .wr_data (f_cmd),
        .ready   (f_ready),
        .rd_en   (q_pop),
        .rd_data (q_cmd),
        .valid   (q_valid)
    );

    // Execute against the task table and present the result.
    tts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .tick_dec  (tick_dec_reg),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign run_valid   = res.run_valid;
    assign run_slot    = res.run_slot;
    assign run_task_id = res.run_task_id;
    assign slot_status = res.slot_status;
    assign restarts    = res.restarts;
    assign task_count  = res.task_count;
    assign error_code  = res.error_code;
endmodule
`default_nettype wire

FILE: rtl/tts_front.sv
// Front stage: accept a request and decode its opcode into one-hot flags.
// Depends on tts_pkg.
`default_nettype none
module tts_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         opcode,
    input  wire logic [7:0]         task_id,
    input  wire logic signed [31:0] sleep_ticks,
    input  wire logic [2:0]         slot_select,
    output logic                    cmd_valid,
    output tts_pkg::cmd_t           cmd,
    input  wire logic               cmd_ready
);
    import tts_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cmd_t      cmd_reg;
    op_flags_t flags;
    logic      take;

    always_comb
    begin
        flags = '0;
        case (opcode)
            OP_ADD:    flags.add    = 1'b1;
            OP_REMOVE: flags.remove = 1'b1;
            OP_DELAY:  flags.delay  = 1'b1;
            OP_TICK:   flags.tick   = 1'b1;
            OP_SCHED:  flags.sched  = 1'b1;
            OP_QUIT:   flags.quit   = 1'b1;
            OP_START:  flags.start  = 1'b1;
            default:   flags.stop   = 1'b1;
        endcase
    end

    assign full       = valid_reg && !cmd_ready;
    assign take       = push && !full;
    assign valid_next = take || (valid_reg && !cmd_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= '{flags: flags, task_id: task_id, sleep_ticks: sleep_ticks,
                         slot_select: slot_select};
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;
endmodule
`default_nettype wire

FILE: rtl/tts_queue.sv
// Short FIFO that decouples the front stage from the execution stage.
// Depends on nothing but its parameters.
`default_nettype none
module tts_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  ready,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  valid
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign ready = (count_reg != CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign do_wr = wr_en && ready;
    assign do_rd = rd_en && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CW'(do_wr) - CW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    assign rd_data = mem[rd_ptr_reg];
endmodule
`default_nettype wire

FILE: rtl/tts_back.sv
// Execution stage: task table, round-robin pointer and result register.
// Depends on tts_pkg.
`default_nettype none
module tts_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire tts_pkg::cmd_t cmd,
    output logic               cmd_pop,
    input  wire logic [7:0]    tick_dec,
    output logic               empty,
    input  wire logic          pop,
    output tts_pkg::res_t      res
);
    import tts_pkg::*;

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    entry_t        tbl_reg  [MAX_TASKS];
    entry_t        tbl_next [MAX_TASKS];
    logic [CW-1:0] used_reg, used_next;
    logic [SW-1:0] rr_reg, rr_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic          res_valid_reg;
    res_t          res_reg, res_next;

    logic          found;
    logic [SW-1:0] hit;
    logic [SW-1:0] slot;
    logic [SW-1:0] sel_idx;
    logic          have, keep, run;
    logic [1:0]    err;
    entry_t        rep;
    logic          cur_ok, sel_ok;

    assign cmd_pop = cmd_valid && (!res_valid_reg || pop);
    assign sel_idx = SW'(cmd.slot_select);
    assign cur_ok  = (32'(cur_reg) < 32'(used_reg));
    assign sel_ok  = (32'(cmd.slot_select) < 32'(used_reg));

    // First valid entry whose id matches.
    always_comb
    begin
        found = 1'b0;
        hit   = '0;
        for (int k = 0; k < MAX_TASKS; k++)
        begin
            if (!found && (32'(k) < 32'(used_reg)) && tbl_reg[k].id == cmd.task_id)
            begin
                found = 1'b1;
                hit   = SW'(k);
            end
        end
    end

    always_comb
    begin
        tbl_next  = tbl_reg;
        used_next = used_reg;
        rr_next   = rr_reg;
        cur_next  = cur_reg;
        err       = ERR_OK;
        have      = 1'b0;
        keep      = 1'b0;
        run       = 1'b0;
        slot      = '0;
        rep       = '0;
        if (cmd.flags.add)
        begin
            if (32'(used_reg) >= MAX_TASKS)
                err = ERR_FULL;
            else
            begin
                slot           = SW'(used_reg);
                tbl_next[slot] = '0;
                tbl_next[slot].id = cmd.task_id;
                used_next      = used_reg + 1'b1;
                have           = 1'b1;
            end
        end
        else if (cmd.flags.remove)
        begin
            err = ERR_NONE;
            if (found)
            begin
                err  = ERR_OK;
                keep = 1'b1;
                slot = hit;
                rep  = tbl_reg[hit];
                // Close the gap; the vacated top slot returns to reset.
                for (int k = 0; k < MAX_TASKS; k++)
                begin
                    if (32'(k) >= 32'(hit))
                    begin
                        if ((k + 1 < MAX_TASKS) && (32'(k + 1) < 32'(used_reg)))
                            tbl_next[k] = tbl_reg[(k + 1) % MAX_TASKS];
                        else
                            tbl_next[k] = '0;
                    end
                end
                used_next = used_reg - 1'b1;
            end
        end
        else if (cmd.flags.delay)
        begin
            if (!cur_ok)
                err = ERR_NONE;
            else
            begin
                slot = cur_reg;
                if (!tbl_reg[slot].sleeping)
                begin
                    tbl_next[slot].sleeping   = 1'b1;
                    tbl_next[slot].status     = ST_SLEEPING;
                    tbl_next[slot].sleep_left = cmd.sleep_ticks;
                end
                have = 1'b1;
            end
        end
        else if (cmd.flags.tick)
        begin
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                if ((32'(k) < 32'(used_reg)) && tbl_reg[k].sleeping)
                begin
                    if (tbl_reg[k].sleep_left[31])
                    begin
                        tbl_next[k].status     = ST_READY;
                        tbl_next[k].sleep_left = '0;
                        tbl_next[k].sleeping   = 1'b0;
                    end
                    else
                        tbl_next[k].sleep_left = tbl_reg[k].sleep_left - {24'd0, tick_dec};
                end
            end
        end
        else if (cmd.flags.sched)
        begin
            if (used_reg == '0)
            begin
                rr_next = '0;
                err     = ERR_NONE;
            end
            else
            begin
                slot = (32'(rr_reg) < 32'(used_reg)) ? rr_reg : '0;
                if (tbl_reg[slot].status == ST_READY)
                begin
                    tbl_next[slot].restarts = tbl_reg[slot].restarts + 16'd1;
                    tbl_next[slot].status   = ST_RUNNING;
                end
                run      = (tbl_next[slot].status == ST_RUNNING);
                cur_next = slot;
                rr_next  = (32'(slot) + 1 >= MAX_TASKS) ? '0 : slot + 1'b1;
                have     = 1'b1;
            end
        end
        else if (cmd.flags.quit)
        begin
            if (!cur_ok)
                err = ERR_NONE;
            else
            begin
                slot = cur_reg;
                tbl_next[slot].status = ST_DEAD;
                have = 1'b1;
            end
        end
        else
        begin
            if (!sel_ok)
                err = ERR_NONE;
            else
            begin
                slot = sel_idx;
                if (cmd.flags.start)
                    tbl_next[slot].status = ST_READY;
                else
                begin
                    tbl_next[slot].status     = ST_DEAD;
                    tbl_next[slot].sleeping   = 1'b0;
                    tbl_next[slot].sleep_left = '0;
                end
                have = 1'b1;
            end
        end

        if (have)
            rep = tbl_next[slot];

        res_next.run_valid   = run;
        res_next.run_slot    = (have || keep) ? 3'(slot) : 3'd0;
        res_next.run_task_id = rep.id;
        res_next.slot_status = rep.status;
        res_next.restarts    = rep.restarts;
        res_next.task_count  = 4'(used_next);
        res_next.error_code  = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_TASKS; k++)
                tbl_reg[k] <= '0;
            used_reg      <= '0;
            rr_reg        <= '0;
            cur_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                tbl_reg  <= tbl_next;
                used_reg <= used_next;
                rr_reg   <= rr_next;
                cur_reg  <= cur_next;
            end
            res_valid_reg <= cmd_pop || (res_valid_reg && !pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            res_reg <= res_next;
    end

    assign empty = !res_valid_reg;
    assign res   = res_reg;
endmodule
`default_nettype wire

FILE: rtl/tts_checker.sv
// Port-level checks of the task table scheduler, bound to the top level.
// Depends on task_table_round_robin_sched_core_defines.svh and tts_pkg.
`default_nettype none
`include "task_table_round_robin_sched_core_defines.svh"
module tts_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        run_valid,
    input wire logic [1:0]  slot_status,
    input wire logic [3:0]  task_count,
    input wire logic [1:0]  error_code,
    input wire logic [15:0] restarts
);
    import tts_pkg::*;

    logic run_ok;

    assign run_ok = (error_code == ERR_OK) && (slot_status == ST_RUNNING);

    `TTS_ASSERT_IMPL(a_err_code, !empty, error_code != 2'd3, "error code out of range")
    `TTS_ASSERT_IMPL(a_run_ok, !empty && run_valid, run_ok, "run without running task")
    `TTS_ASSERT_IMPL(a_count, !empty, 32'(task_count) <= MAX_TASKS, "task count above table size")
    `TTS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(task_count) && $stable(restarts), "stalled result changed")
endmodule

bind task_table_round_robin_sched_core tts_port_checker u_tts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .run_valid   (run_valid),
    .slot_status (slot_status),
    .task_count  (task_count),
    .error_code  (error_code),
    .restarts    (restarts)
);
`default_nettype wire

FILE: tb/tts_checker.sv
// Scoreboard for the task table scheduler: mirrors the task table, predicts
// each result from accepted requests and register writes. Depends on tts_pkg.
`default_nettype none
module tts_checker
    import tts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               pready,
    input  wire logic               push,
    input  wire logic               full,
    input  wire logic [2:0]         opcode,
    input  wire logic [7:0]         task_id,
    input  wire logic signed [31:0] sleep_ticks,
    input  wire logic [2:0]         slot_select,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire logic               run_valid,
    input  wire logic [2:0]         run_slot,
    input  wire logic [7:0]         run_task_id,
    input  wire logic [1:0]         slot_status,
    input  wire logic [15:0]        restarts,
    input  wire logic [3:0]         task_count,
    input  wire logic [1:0]         error_code,
    output int                      fail_count,
    output int                      pending_count
);

    entry_t     table_q [MAX_TASKS];
    int         used_q;
    int         rr_q;
    int         cur_q;
    logic [7:0] dec_q;
    res_t       expected_results [$];

    assign pending_count = expected_results.size();

    function automatic entry_t blank_entry();
        entry_t e;
        e = '0;
        e.status = ST_READY;
        return e;
    endfunction

    // Advance the mirror by one request and return the result it causes.
    task automatic schedule_step(input logic [2:0] op, input logic [7:0] tid,
                                 input logic [31:0] ticks, input logic [2:0] sel,
                                 output res_t r);
        int  i;
        int  j;
        int  s;
        bit  have;
        bit  found;
        r = '0;
        have = 0;
        s = 0;
        r.error_code = ERR_OK;
        case (op)
            OP_ADD:
                if (used_q >= MAX_TASKS) r.error_code = ERR_FULL;
                else
                begin
                    s = used_q;
                    table_q[s] = blank_entry();
                    table_q[s].id = tid;
                    used_q++;
                    have = 1;
                end
            OP_REMOVE:
            begin
                found = 0;
                r.error_code = ERR_NONE;
                for (i = 0; i < used_q && !found; i++)
                    if (table_q[i].id == tid)
                    begin
                        found = 1;
                        r.run_slot = 3'(i);
                        r.run_task_id = table_q[i].id;
                        r.slot_status = table_q[i].status;
                        r.restarts = table_q[i].restarts;
                        for (j = i + 1; j < used_q; j++) table_q[j-1] = table_q[j];
                        used_q--;
                        table_q[used_q] = blank_entry();
                        r.error_code = ERR_OK;
                    end
            end
            OP_DELAY:
                if (cur_q >= used_q) r.error_code = ERR_NONE;
                else
                begin
                    s = cur_q;
                    if (!table_q[s].sleeping)
                    begin
                        table_q[s].sleeping = 1;
                        table_q[s].status = ST_SLEEPING;
                        table_q[s].sleep_left = ticks;
                    end
                    have = 1;
                end
            OP_TICK:
                for (i = 0; i < used_q; i++)
                    if (table_q[i].sleeping)
                    begin
                        if (table_q[i].sleep_left[31])
                        begin
                            table_q[i].status = ST_READY;
                            table_q[i].sleep_left = '0;
                            table_q[i].sleeping = 0;
                        end
                        else table_q[i].sleep_left -= {24'd0, dec_q};
                    end
            OP_SCHED:
                if (used_q == 0)
                begin
                    rr_q = 0;
                    r.error_code = ERR_NONE;
                end
                else
                begin
                    s = (rr_q >= used_q) ? 0 : rr_q;
                    if (table_q[s].status == ST_READY)
                    begin
                        table_q[s].restarts++;
                        table_q[s].status = ST_RUNNING;
                    end
                    r.run_valid = (table_q[s].status == ST_RUNNING);
                    cur_q = s;
                    rr_q = (s + 1 >= MAX_TASKS) ? 0 : s + 1;
                    have = 1;
                end
            OP_QUIT:
                if (cur_q >= used_q) r.error_code = ERR_NONE;
                else
                begin
                    s = cur_q;
                    table_q[s].status = ST_DEAD;
                    have = 1;
                end
            default:
                if (sel >= used_q) r.error_code = ERR_NONE;
                else
                begin
                    s = sel;
                    if (op == OP_START) table_q[s].status = ST_READY;
                    else
                    begin
                        table_q[s].status = ST_DEAD;
                        table_q[s].sleeping = 0;
                        table_q[s].sleep_left = '0;
                    end
                    have = 1;
                end
        endcase
        if (have)
        begin
            r.run_slot = 3'(s);
            r.run_task_id = table_q[s].id;
            r.slot_status = table_q[s].status;
            r.restarts = table_q[s].restarts;
        end
        r.task_count = 4'(used_q);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_TASKS; k++) table_q[k] = blank_entry();
            used_q = 0;
            rr_q = 0;
            cur_q = 0;
            dec_q = TICK_DEC_RESET;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == 2'd0) dec_q = pwdata[7:0];
            if (pop && !empty)
            begin
                got = '{run_valid, run_slot, run_task_id, slot_status, restarts,
                        task_count, error_code};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (push && !full)
            begin
                schedule_step(opcode, task_id, sleep_ticks, slot_select, want);
                expected_results.push_back(want);
            end
        end
    end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Stimulus top for the task table scheduler: drives requests, register
// writes and result pops. Depends on tts_pkg, tts_checker and the RTL.
`default_nettype none
module tb_top;
    import tts_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               psel = 0;
    logic               penable = 0;
    logic               pwrite = 0;
    logic [1:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               push = 0;
    logic               full;
    logic [2:0]         opcode = OP_TICK;
    logic [7:0]         task_id = '0;
    logic signed [31:0] sleep_ticks = '0;
    logic [2:0]         slot_select = '0;
    logic               empty;
    logic               pop = 0;
    logic               run_valid;
    logic [2:0]         run_slot;
    logic [7:0]         run_task_id;
    logic [1:0]         slot_status;
    logic [15:0]        restarts;
    logic [3:0]         task_count;
    logic [1:0]         error_code;
    int                 fail_count;
    int                 pending_count;
    int                 push_idle_pct;
    int                 pop_idle_pct;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    task_table_round_robin_sched_core dut (.*);
    tts_checker chk (.*);

    // Drain randomly: pop stays high for a cycle with probability set by phase.
    always @(posedge clk)
        pop <= ($urandom_range(99) >= pop_idle_pct);

    // Push one request and hold it until the block takes it; push stays high
    // so back-to-back requests need no second drive in the same step.
    task automatic send_request(input logic [2:0] op, input logic [7:0] tid,
                                input logic [31:0] ticks, input logic [2:0] sel);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1;
        opcode <= op;
        task_id <= tid;
        sleep_ticks <= ticks;
        slot_select <= sel;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // Drop push, wait for every expected result, then let the pipeline settle.
    task automatic drain_all();
        push <= 0;
        while (pending_count != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Program the tick step with a setup phase followed by an access phase.
    task automatic write_tick_step(input logic [7:0] val);
        psel <= 1;
        pwrite <= 1;
        paddr <= 2'd0;
        pwdata <= {24'd0, val};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // Mostly add/schedule/delay/tick over a small id space so removes hit.
    task automatic random_request();
        logic [2:0]  op;
        logic [31:0] t;
        int          w;
        w = $urandom_range(99);
        if (w < 18) op = OP_ADD;
        else if (w < 28) op = OP_REMOVE;
        else if (w < 42) op = OP_DELAY;
        else if (w < 60) op = OP_TICK;
        else if (w < 82) op = OP_SCHED;
        else op = 3'($urandom_range(5, 7));
        case ($urandom_range(3))
            0: t = $urandom;
            1: t = $urandom_range(12);
            2: t = -$urandom_range(3);
            default: t = $urandom_range(40);
        endcase
        send_request(op, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
                     t, 3'($urandom));
    endtask

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        push_idle_pct = 0;
        pop_idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Directed: empty-table errors, fill past full, field extremes.
        send_request(OP_SCHED, 8'd0, 32'd0, 3'd0);
        send_request(OP_DELAY, 8'd0, 32'd0, 3'd0);
        send_request(OP_QUIT, 8'd0, 32'd0, 3'd0);
        send_request(OP_START, 8'd0, 32'd0, 3'd7);
        send_request(OP_REMOVE, 8'd5, 32'd0, 3'd0);
        for (int k = 0; k < 9; k++)
            send_request(OP_ADD, (k == 0) ? 8'hFF : 8'(k), 32'd0, 3'd0);
        send_request(OP_SCHED, 8'd0, 32'd0, 3'd0);
        send_request(OP_DELAY, 8'd0, 32'h7FFFFFFF, 3'd0);
        send_request(OP_DELAY, 8'd0, 32'd3, 3'd0);
        send_request(OP_TICK, 8'd0, 32'd0, 3'd0);
        send_request(OP_SCHED, 8'd0, 32'd0, 3'd0);
        send_request(OP_DELAY, 8'd0, 32'h80000000, 3'd0);
        send_request(OP_TICK, 8'd0, 32'd0, 3'd0);
        send_request(OP_QUIT, 8'd0, 32'd0, 3'd0);
        send_request(OP_STOP, 8'd0, 32'd0, 3'd7);
        send_request(OP_START, 8'd0, 32'd0, 3'd1);
        send_request(OP_REMOVE, 8'hFF, 32'd0, 3'd0);
        drain_all();
        // Random phases: tick step changes between them, extremes included.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_tick_step(8'd1);
                1: write_tick_step(8'd255);
                default: write_tick_step(8'($urandom_range(1, 255)));
            endcase
            push_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 62 : 0;
            pop_idle_pct = (ph < 2) ? 62 : (ph < 4) ? 25 : 0;
            for (int n = 0; n < 300; n++) random_request();
            drain_all();
        end
        pop_idle_pct = 0;
        drain_all();
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
